>>> rtl/core/ptbc_pkg.sv
// Shared types and constants for the prime tuplet byte counter.
`default_nettype none

package ptbc_pkg;

	localparam int unsigned COUNTER_BITS_DEFAULT = 64;
	localparam int unsigned TOTAL_W              = 64;
	localparam int unsigned NUM_TOTALS           = 7;
	localparam int unsigned INC_W                = 4;
	localparam int unsigned BYTE_W               = 8;

	typedef enum logic [2:0] {
		TOT_PRIME = 3'd0,
		TOT_TWIN  = 3'd1,
		TOT_TRIP  = 3'd2,
		TOT_QUAD  = 3'd3,
		TOT_QUINT = 3'd4,
		TOT_SEXT  = 3'd5,
		TOT_SEPT  = 3'd6
	} total_idx_t;

	typedef logic [BYTE_W-1:0]                  byte_t;
	typedef logic [INC_W-1:0]                   inc_t;
	typedef logic [NUM_TOTALS-1:0][INC_W-1:0]   inc_vec_t;
	typedef logic [NUM_TOTALS-1:0]              enable_t;

	localparam byte_t TWIN_MASK_A  = 8'h06;
	localparam byte_t TWIN_MASK_B  = 8'h18;
	localparam byte_t TWIN_MASK_C  = 8'hc0;
	localparam byte_t TRIP_MASK_A  = 8'h07;
	localparam byte_t TRIP_MASK_B  = 8'h0e;
	localparam byte_t TRIP_MASK_C  = 8'h1c;
	localparam byte_t TRIP_MASK_D  = 8'h38;
	localparam byte_t QUAD_MASK    = 8'h1e;
	localparam byte_t QUINT_MASK_A = 8'h1f;
	localparam byte_t QUINT_MASK_B = 8'h3e;
	localparam byte_t SEXT_MASK    = 8'h3f;
	localparam byte_t SEPT_MASK    = 8'hfe;

	localparam enable_t ENABLE_RESET = 7'h01;

endpackage

`default_nettype wire

>>> rtl/core/ptbc_if.sv
// Channel interfaces for sieve bytes, segment totals and the enable register.
`default_nettype none

interface ptbc_in_if;
	logic               valid;
	logic               ready;
	ptbc_pkg::byte_t    sieve_byte;
	logic               end_of_segment;

	modport source (output valid, output sieve_byte, output end_of_segment, input ready);
	modport sink   (input valid, input sieve_byte, input end_of_segment, output ready);
endinterface

interface ptbc_out_if;
	logic                          valid;
	logic                          ready;
	logic [ptbc_pkg::TOTAL_W-1:0]  prime_total;
	logic [ptbc_pkg::TOTAL_W-1:0]  twin_total;
	logic [ptbc_pkg::TOTAL_W-1:0]  triplet_total;
	logic [ptbc_pkg::TOTAL_W-1:0]  quadruplet_total;
	logic [ptbc_pkg::TOTAL_W-1:0]  quintuplet_total;
	logic [ptbc_pkg::TOTAL_W-1:0]  sextuplet_total;
	logic [ptbc_pkg::TOTAL_W-1:0]  septuplet_total;

	modport source (output valid, output prime_total, output twin_total,
		output triplet_total, output quadruplet_total, output quintuplet_total,
		output sextuplet_total, output septuplet_total, input ready);
	modport sink   (input valid, input prime_total, input twin_total,
		input triplet_total, input quadruplet_total, input quintuplet_total,
		input sextuplet_total, input septuplet_total, output ready);
endinterface

interface ptbc_cfg_if;
	logic                 valid;
	logic                 ready;
	ptbc_pkg::enable_t    count_enable;

	modport source (output valid, output count_enable, input ready);
	modport sink   (input valid, input count_enable, output ready);
endinterface

`default_nettype wire

>>> rtl/core/ptbc_tally.sv
// Per-byte increments: popcount and k-tuplet mask matches.
`default_nettype none

module ptbc_tally (
	input  ptbc_pkg::byte_t    sieve_byte,
	output ptbc_pkg::inc_vec_t incs
);
	import ptbc_pkg::*;

	function automatic inc_t hit(input byte_t b, input byte_t m);
		return inc_t'((b & m) == m);
	endfunction

	inc_t pop;

	always_comb begin
		pop = '0;
		for (int i = 0; i < BYTE_W; i++) begin
			pop = pop + inc_t'(sieve_byte[i]);
		end
	end

	always_comb begin
		incs            = '0;
		incs[TOT_PRIME] = pop;
		incs[TOT_TWIN]  = hit(sieve_byte, TWIN_MASK_A) + hit(sieve_byte, TWIN_MASK_B)
			+ hit(sieve_byte, TWIN_MASK_C);
		incs[TOT_TRIP]  = hit(sieve_byte, TRIP_MASK_A) + hit(sieve_byte, TRIP_MASK_B)
			+ hit(sieve_byte, TRIP_MASK_C) + hit(sieve_byte, TRIP_MASK_D);
		incs[TOT_QUAD]  = hit(sieve_byte, QUAD_MASK);
		incs[TOT_QUINT] = hit(sieve_byte, QUINT_MASK_A) + hit(sieve_byte, QUINT_MASK_B);
		incs[TOT_SEXT]  = hit(sieve_byte, SEXT_MASK);
		incs[TOT_SEPT]  = hit(sieve_byte, SEPT_MASK);
	end

endmodule

`default_nettype wire

>>> rtl/core/prime_tuplet_byte_counter.sv
// Top level: running prime and k-tuplet totals over a mod-30 wheel sieve stream.
`default_nettype none

// Takes one sieve byte per clock cycle and keeps seven saturating totals
// (primes, then twins up to septuplets) of COUNTER_BITS bits each, counting
// only those enabled in count_enable. A byte flagged end_of_segment, once
// counted, places all seven totals in the result register; the byte passes
// the input register, then its totals load the result register. Throughput
// is one byte per cycle, set by the input register feeding the totals
// register through the mask and adder logic; the input stalls only while a
// result waits in the result register and the next segment end is already
// queued behind it. count_enable resets to primes only; the user must write
// it only while the block is idle, which the block itself does not enforce.
module prime_tuplet_byte_counter #(
	parameter int unsigned COUNTER_BITS = ptbc_pkg::COUNTER_BITS_DEFAULT
) (
	input  logic               clk,
	input  logic               arst_n,
	ptbc_cfg_if.sink           cfg,
	ptbc_in_if.sink            sieve,
	ptbc_out_if.source         totals
);
	import ptbc_pkg::*;

	typedef logic [COUNTER_BITS-1:0] count_t;
	typedef logic [COUNTER_BITS:0]   count_sum_t;

	enable_t    enable_q;
	logic       valid_s1;
	byte_t      byte_s1;
	logic       eos_s1;
	count_t     tot_q   [NUM_TOTALS];
	count_t     tot_nxt [NUM_TOTALS];
	count_sum_t tot_sum [NUM_TOTALS];
	count_t     res_q   [NUM_TOTALS];
	logic       out_valid_q;
	inc_vec_t   incs;
	logic       s1_fire;
	logic       load_res;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= ENABLE_RESET;
		end else if (cfg.valid) begin
			enable_q <= cfg.count_enable;
		end
	end

	assign s1_fire     = valid_s1 && (!eos_s1 || !out_valid_q || totals.ready);
	assign load_res    = s1_fire && eos_s1;
	assign sieve.ready = !valid_s1 || s1_fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sieve.ready) begin
			valid_s1 <= sieve.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sieve.valid && sieve.ready) begin
			byte_s1 <= sieve.sieve_byte;
			eos_s1  <= sieve.end_of_segment;
		end
	end

	ptbc_tally u_tally (
		.sieve_byte (byte_s1),
		.incs       (incs)
	);

	always_comb begin
		for (int k = 0; k < NUM_TOTALS; k++) begin
			tot_sum[k] = {1'b0, tot_q[k]} + count_sum_t'(incs[k]);
			if (!enable_q[k]) begin
				tot_nxt[k] = tot_q[k];
			end else if (tot_sum[k][COUNTER_BITS]) begin
				tot_nxt[k] = '1;
			end else begin
				tot_nxt[k] = tot_sum[k][COUNTER_BITS-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_TOTALS; k++) begin
				tot_q[k] <= '0;
			end
		end else if (s1_fire) begin
			for (int k = 0; k < NUM_TOTALS; k++) begin
				tot_q[k] <= tot_nxt[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_res) begin
			for (int k = 0; k < NUM_TOTALS; k++) begin
				res_q[k] <= tot_nxt[k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_res) begin
			out_valid_q <= 1'b1;
		end else if (totals.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign totals.valid            = out_valid_q;
	assign totals.prime_total      = TOTAL_W'(res_q[TOT_PRIME]);
	assign totals.twin_total       = TOTAL_W'(res_q[TOT_TWIN]);
	assign totals.triplet_total    = TOTAL_W'(res_q[TOT_TRIP]);
	assign totals.quadruplet_total = TOTAL_W'(res_q[TOT_QUAD]);
	assign totals.quintuplet_total = TOTAL_W'(res_q[TOT_QUINT]);
	assign totals.sextuplet_total  = TOTAL_W'(res_q[TOT_SEXT]);
	assign totals.septuplet_total  = TOTAL_W'(res_q[TOT_SEPT]);

	a_res_from_eos: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(s1_fire && eos_s1))
		else $error("result raised without a segment end");

	a_prime_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		tot_q[TOT_PRIME] >= $past(tot_q[TOT_PRIME]))
		else $error("prime total decreased");

	a_disabled_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(enable_q[TOT_SEPT]) |-> $stable(tot_q[TOT_SEPT]))
		else $error("disabled septuplet total changed");

	a_eos_stall: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && eos_s1 && out_valid_q && !totals.ready |-> !sieve.ready)
		else $error("input taken while segment end blocked");

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !totals.ready |=> out_valid_q && $stable(res_q[TOT_PRIME]))
		else $error("stalled result changed");

endmodule

`default_nettype wire
